// ===== rtl/dda_line_rasterizer_assert.svh =====
// Assertion macros used by the checker of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rasterizer check failed");

// Consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rasterizer check failed");

`endif

// ===== rtl/dda_pkg.sv =====
package dda_pkg;

  localparam int COORD_BITS = 6;
  localparam int FRAC_BITS  = 16;
  localparam int COLOR_BITS = 32;
  localparam int ACC_W      = COORD_BITS + FRAC_BITS;
  localparam int DIV_W      = ACC_W;
  localparam int CNT_W      = $clog2(DIV_W + 1);

  typedef struct packed {
    logic load;
    logic div_start;
    logic init_draw;
    logic emit;
  } dda_cmd_t;

  typedef struct packed {
    logic zero_len;
    logic div_done;
    logic last_step;
  } dda_stat_t;

endpackage

// ===== rtl/dda_line_rasterizer.sv =====
// A request passes through setup and a bit-serial slope divider before the first pixel strobes.
// While a line draws, one pixel per cycle; a new line is accepted only once busy drops.
// A zero-length request emits nothing; busy is high only while it passes the setup state.
// The receiver cannot stall: each pixel is on the outputs for exactly one cycle.
// Reset (rst_n low, synchronous) returns to idle and drops any line in flight.
module dda_line_rasterizer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_start_x,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_start_y,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_end_x,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0]     in_line_color,
  output logic                               out_valid,
  output logic [dda_pkg::COORD_BITS-1:0]     out_pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0]     out_pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0]     out_pixel_color,
  output logic                               out_last_pixel
);
  import dda_pkg::*;

  dda_cmd_t  cmd;
  dda_stat_t stat;

  dda_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  dda_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_line_color   (in_line_color),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_pixel  (out_last_pixel)
  );

endmodule

// ===== rtl/dda_div.sv =====
module dda_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [dda_pkg::DIV_W-1:0]          dividend,
  input  logic [dda_pkg::COORD_BITS-1:0]     divisor,
  output logic                               done,
  output logic [dda_pkg::DIV_W-1:0]          quotient
);
  import dda_pkg::*;

  logic                  active_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIV_W-1:0]      dvd_r;
  logic [DIV_W-1:0]      q_r;
  logic [COORD_BITS-1:0] rem_r;
  logic [COORD_BITS:0]   trial;
  logic [COORD_BITS:0]   diff;
  logic                  ge;

  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= CNT_W'(DIV_W);
      end else if (active_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      q_r   <= '0;
    end else if (active_r) begin
      rem_r <= ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/dda_datapath.sv =====
module dda_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  dda_pkg::dda_cmd_t                  cmd,
  output dda_pkg::dda_stat_t                 stat,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_start_x,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_start_y,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_end_x,
  input  logic [dda_pkg::COORD_BITS-1:0]     in_end_y,
  input  logic [dda_pkg::COLOR_BITS-1:0]     in_line_color,
  output logic                               out_valid,
  output logic [dda_pkg::COORD_BITS-1:0]     out_pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0]     out_pixel_y,
  output logic [dda_pkg::COLOR_BITS-1:0]     out_pixel_color,
  output logic                               out_last_pixel
);
  import dda_pkg::*;

  logic                  dx_neg, dy_neg, xm;
  logic [COORD_BITS-1:0] ax, ay;

  logic                  x_major_r;
  logic                  major_neg_r;
  logic                  step_neg_r;
  logic [COORD_BITS-1:0] major_r;
  logic [COORD_BITS-1:0] minor_start_r;
  logic [COORD_BITS-1:0] count_r;
  logic [COORD_BITS-1:0] mnr_r;
  logic [COLOR_BITS-1:0] color_r;
  logic [ACC_W-1:0]      acc_r;
  logic [ACC_W-1:0]      step_r;

  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [COLOR_BITS-1:0] pc_r;
  logic                  plast_r;

  logic                  div_done;
  logic [DIV_W-1:0]      quotient;
  logic [COORD_BITS-1:0] minor_now;

  assign dx_neg = in_end_x < in_start_x;
  assign dy_neg = in_end_y < in_start_y;
  assign ax     = dx_neg ? in_start_x - in_end_x : in_end_x - in_start_x;
  assign ay     = dy_neg ? in_start_y - in_end_y : in_end_y - in_start_y;
  assign xm     = ax > ay;

  dda_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({mnr_r, {FRAC_BITS{1'b0}}}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign minor_now = acc_r[ACC_W-1:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major_r     <= xm;
      major_r       <= xm ? in_start_x : in_start_y;
      minor_start_r <= xm ? in_start_y : in_start_x;
      count_r       <= xm ? ax : ay;
      mnr_r         <= xm ? ay : ax;
      major_neg_r   <= xm ? dx_neg : dy_neg;
      step_neg_r    <= (xm ? dy_neg : dx_neg) ^ (xm ? dx_neg : dy_neg);
      color_r       <= in_line_color;
    end else if (cmd.init_draw) begin
      acc_r  <= {minor_start_r, {FRAC_BITS{1'b0}}};
      step_r <= step_neg_r ? ACC_W'(0) - quotient : quotient;
    end else if (cmd.emit) begin
      major_r <= major_neg_r ? major_r - COORD_BITS'(1) : major_r + COORD_BITS'(1);
      acc_r   <= acc_r + step_r;
      count_r <= count_r - COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      px_r    <= x_major_r ? major_r : minor_now;
      py_r    <= x_major_r ? minor_now : major_r;
      pc_r    <= color_r;
      plast_r <= count_r == COORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign stat.zero_len  = count_r == '0;
  assign stat.div_done  = div_done;
  assign stat.last_step = count_r == COORD_BITS'(1);

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pc_r;
  assign out_last_pixel  = plast_r;

endmodule

// ===== rtl/dda_ctrl.sv =====
module dda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dda_pkg::dda_stat_t stat,
  output dda_pkg::dda_cmd_t  cmd
);
  import dda_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_DIVIDE,
    S_DRAW
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        if (stat.zero_len) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          cmd.init_draw = 1'b1;
          state_nxt     = S_DRAW;
        end
      end
      S_DRAW: begin
        cmd.emit = 1'b1;
        if (stat.last_step) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

// ===== rtl/dda_checker.sv =====
`include "dda_line_rasterizer_assert.svh"

module dda_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [dda_pkg::COLOR_BITS-1:0]     out_pixel_color,
  input logic                               out_last_pixel
);
  import dda_pkg::*;

  `DDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DDA_ASSERT_NEXT(a_pixels_run, out_valid && !out_last_pixel, out_valid)
  `DDA_ASSERT_SAME(a_mid_line_busy, out_valid && !out_last_pixel, busy)
  `DDA_ASSERT_NEXT(a_gap_after_last, out_valid && out_last_pixel, !out_valid)
  `DDA_ASSERT_NEXT(a_color_held, out_valid && !out_last_pixel,
                   out_pixel_color == $past(out_pixel_color))

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dda_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic [COLOR_BITS-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [COORD_BITS-1:0] in_start_x = '0;
  logic [COORD_BITS-1:0] in_start_y = '0;
  logic [COORD_BITS-1:0] in_end_x = '0;
  logic [COORD_BITS-1:0] in_end_y = '0;
  logic [COLOR_BITS-1:0] in_line_color = '0;
  logic                  out_valid;
  logic [COORD_BITS-1:0] out_pixel_x;
  logic [COORD_BITS-1:0] out_pixel_y;
  logic [COLOR_BITS-1:0] out_pixel_color;
  logic                  out_last_pixel;

  line_cmd_t line_queue[$];
  pixel_t    pixel_queue[$];
  line_cmd_t held_line;
  pixel_t    want_px;
  int        err_count = 0;
  int        cycle_count = 0;
  int        lines_issued = 0;
  bit        go;

  dda_line_rasterizer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_line_color  (in_line_color),
    .out_valid      (out_valid),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_pixel_color(out_pixel_color),
    .out_last_pixel (out_last_pixel)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void trace_line(line_cmd_t c);
    int                    rx, ry, ax, ay, major, major_range, minor_range;
    int                    count, dir, num_mag, den_mag, k;
    bit                    x_major, neg;
    logic [63:0]           mag, step, acc;
    logic [COORD_BITS-1:0] major_c, minor_c, minor_start;
    pixel_t                p;
    rx = int'(c.ex) - int'(c.sx);
    ry = int'(c.ey) - int'(c.sy);
    ax = rx < 0 ? -rx : rx;
    ay = ry < 0 ? -ry : ry;
    x_major = ax > ay;
    major = x_major ? int'(c.sx) : int'(c.sy);
    minor_start = x_major ? c.sy : c.sx;
    major_range = x_major ? rx : ry;
    minor_range = x_major ? ry : rx;
    count = major_range < 0 ? -major_range : major_range;
    dir = major_range < 0 ? -1 : 1;
    if (count == 0) return;
    num_mag = minor_range < 0 ? -minor_range : minor_range;
    den_mag = count;
    mag = (64'(num_mag) << FRAC_BITS) / 64'(den_mag);
    neg = (minor_range < 0) != (major_range < 0);
    step = neg ? 64'd0 - mag : mag;
    acc = 64'(minor_start) << FRAC_BITS;
    for (k = 0; k < count; k++) begin
      major_c = major[COORD_BITS-1:0];
      minor_c = acc[FRAC_BITS +: COORD_BITS];
      p.x = x_major ? major_c : minor_c;
      p.y = x_major ? minor_c : major_c;
      p.color = c.color;
      p.last = (k == count - 1);
      pixel_queue.push_back(p);
      major += dir;
      acc += step;
    end
  endfunction

  function automatic int near(int c, int span);
    int lo, hi;
    lo = c - span < 0 ? 0 : c - span;
    hi = c + span > 63 ? 63 : c + span;
    return $urandom_range(hi, lo);
  endfunction

  task automatic add_line(int x0, int y0, int x1, int y1, logic [COLOR_BITS-1:0] color);
    line_cmd_t c;
    c.sx = COORD_BITS'(x0);
    c.sy = COORD_BITS'(y0);
    c.ex = COORD_BITS'(x1);
    c.ey = COORD_BITS'(y1);
    c.color = color;
    line_queue.push_back(c);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) trace_line(held_line);
      go = (lines_issued >= 150 && lines_issued < 230) || ($urandom_range(0, 99) >= 23);
      if (line_queue.size() != 0 && go) begin
        held_line = line_queue.pop_front();
        in_start_x <= held_line.sx;
        in_start_y <= held_line.sy;
        in_end_x <= held_line.ex;
        in_end_y <= held_line.ey;
        in_line_color <= held_line.color;
        start <= 1'b1;
        lines_issued++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d color=%08h last=%0b",
               out_pixel_x, out_pixel_y, out_pixel_color, out_last_pixel);
        err_count++;
      end else begin
        want_px = pixel_queue.pop_front();
        if (out_pixel_x !== want_px.x) begin
          $error("pixel_x: expected %0d, got %0d", want_px.x, out_pixel_x);
          err_count++;
        end
        if (out_pixel_y !== want_px.y) begin
          $error("pixel_y: expected %0d, got %0d", want_px.y, out_pixel_y);
          err_count++;
        end
        if (out_pixel_color !== want_px.color) begin
          $error("pixel_color: expected %08h, got %08h", want_px.color, out_pixel_color);
          err_count++;
        end
        if (out_last_pixel !== want_px.last) begin
          $error("last_pixel: expected %0b, got %0b", want_px.last, out_last_pixel);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i, kind, x0, y0, x1, y1, d;
    add_line(0, 0, 0, 0, 32'h0000_0000);
    add_line(63, 63, 63, 63, 32'hFFFF_FFFF);
    add_line(0, 0, 63, 0, 32'hFFFF_FFFF);
    add_line(63, 63, 0, 63, 32'h0000_0000);
    add_line(0, 0, 0, 63, 32'hA5A5_A5A5);
    add_line(63, 63, 63, 0, 32'h5A5A_5A5A);
    add_line(0, 0, 63, 63, 32'h0123_4567);
    add_line(63, 0, 0, 63, 32'h89AB_CDEF);
    add_line(0, 63, 63, 0, 32'hFEDC_BA98);
    add_line(0, 0, 63, 1, 32'h7654_3210);
    add_line(63, 63, 0, 62, 32'hFFFF_0000);
    add_line(0, 0, 1, 63, 32'h0000_FFFF);
    add_line(63, 0, 62, 63, 32'hFF00_FF00);
    add_line(5, 5, 6, 5, 32'h00FF_00FF);
    add_line(5, 5, 5, 4, 32'h8000_0001);
    add_line(10, 20, 50, 41, 32'h1357_9BDF);
    add_line(50, 41, 10, 20, 32'h2468_ACE0);
    add_line(0, 63, 62, 0, 32'hDEAD_BEEF);
    add_line(2, 1, 1, 2, 32'hC0FF_EE00);
    add_line(32, 32, 0, 31, 32'h0F0F_0F0F);
    for (i = 0; i < 340; i++) begin
      kind = $urandom_range(0, 99);
      x0 = $urandom_range(0, 63);
      y0 = $urandom_range(0, 63);
      if (kind < 5) begin
        x1 = x0;
        y1 = y0;
      end else if (kind < 15) begin
        x1 = kind < 10 ? $urandom_range(0, 63) : x0;
        y1 = kind < 10 ? y0 : $urandom_range(0, 63);
      end else if (kind < 22) begin
        x1 = $urandom_range(0, 63);
        d = x1 > x0 ? x1 - x0 : x0 - x1;
        y0 = $urandom_range(63 - d, 0);
        y1 = y0 + d;
        if ($urandom_range(0, 1)) begin
          d = y0;
          y0 = y1;
          y1 = d;
        end
      end else if (kind < 60) begin
        x1 = near(x0, 6);
        y1 = near(y0, 6);
      end else begin
        x1 = $urandom_range(0, 63);
        y1 = $urandom_range(0, 63);
      end
      add_line(x0, y0, x1, y1, $urandom);
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (line_queue.size() != 0 || start) @(posedge clk);
    while (pixel_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
